/* hw/rtl/heq_pkg.sv */
// shared types, constants and helpers of the histogram equalization block
package heq_pkg;

  localparam int LEVELS     = 256;
  localparam int COUNT_BITS = 22;
  localparam int PIX_W      = 8;
  localparam int LEVEL_W    = 8;
  localparam int IDX_W      = $clog2(LEVELS);
  localparam int PROD_W     = COUNT_BITS + LEVEL_W;
  localparam int STEP_W     = $clog2(LEVEL_W);
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [PIX_W-1:0]      pix_t;

  localparam count_t TOTAL_MAX = '1;
  localparam idx_t   LAST_IDX  = IDX_W'(LEVELS - 1);
  localparam logic [ADDR_W-3:0] REG_MAX_LEVEL = '0;
  localparam level_t MAX_LEVEL_RST = 8'd255;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_MAP   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // request to the level unit: floor(cum * level / total)
  typedef struct packed {
    logic   start;
    count_t cum;
    level_t level;
    count_t total;
  } lvl_req_t;

  typedef struct packed {
    logic   done;
    level_t quot;
  } lvl_rsp_t;

  // clamp a pixel to max_level and to the top bin
  function automatic idx_t clamp_idx(input pix_t pix, input level_t lvl);
    pix_t v;
    v = (pix > lvl) ? lvl : pix;
    if (v > PIX_W'(LEVELS - 1)) v = PIX_W'(LEVELS - 1);
    return IDX_W'(v);
  endfunction

endpackage

/* hw/rtl/heq_ram.sv */
// generic simple dual-port ram with registered read
module heq_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/heq_lvl.sv */
// level unit: one multiply, then restoring division one quotient bit per cycle
module heq_lvl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  heq_pkg::lvl_req_t req_i,
  output heq_pkg::lvl_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_MUL  = 3'b010,
    L_DIV  = 3'b100
  } lvl_state_e;

  lvl_state_e                    state_q, state_d;
  logic                          done_q, done_d;
  heq_pkg::count_t               cum_q, cum_d;
  heq_pkg::count_t               div_q, div_d;
  heq_pkg::level_t               lvl_q, lvl_d;
  heq_pkg::level_t               quot_q, quot_d;
  logic [heq_pkg::PROD_W-1:0]    rem_q, rem_d;
  logic [heq_pkg::STEP_W-1:0]    step_q, step_d;
  logic [heq_pkg::PROD_W-1:0]    prod;
  logic [heq_pkg::PROD_W-1:0]    trial;
  logic                          ge;

  assign prod  = cum_q * lvl_q;
  assign trial = heq_pkg::PROD_W'(div_q) << step_q;
  // empty histogram: zero divisor never subtracts, quotient stays zero
  assign ge    = (div_q != '0) && (rem_q >= trial);

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cum_d   = cum_q;
    div_d   = div_q;
    lvl_d   = lvl_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    step_d  = step_q;
    unique case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          cum_d   = req_i.cum;
          div_d   = req_i.total;
          lvl_d   = req_i.level;
          quot_d  = '0;
          state_d = L_MUL;
        end
      end
      L_MUL: begin
        rem_d   = prod;
        step_d  = heq_pkg::STEP_W'(heq_pkg::LEVEL_W - 1);
        state_d = L_DIV;
      end
      L_DIV: begin
        if (ge) rem_d = rem_q - trial;
        quot_d[step_q] = ge;
        if (step_q == '0) begin
          done_d  = 1'b1;
          state_d = L_IDLE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cum_q  <= cum_d;
    div_q  <= div_d;
    lvl_q  <= lvl_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    step_q <= step_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

/* hw/rtl/histogram_equalization.sv */
// top level of the two-pass histogram equalization block
// Two-pass histogram equalization of 8-bit luminance. Clear items zero the
// histogram by dropping the valid bit that each bin carries (so there is no
// clearing pass after reset). Count items stream at one per cycle: the bin
// memory is read on transfer and written back the next cycle, with forwarding
// when two back-to-back counts hit the same bin; counting saturates once the
// total reaches 2^COUNT_BITS-1. The first map item after any counted pixel,
// clear or max_level write rebuilds the level table by walking all bins;
// each bin passes through the level unit's multiply and its one-bit-per-cycle
// 8-step divider. Later map items read the level table. Results go to an
// output register, so a new item can be taken while a result waits.
// max_level sits at byte address 0 of the APB port.
module histogram_equalization (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     op_i,
  input  logic [heq_pkg::PIX_W-1:0]      pixel_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [heq_pkg::LEVEL_W-1:0]    mapped_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [heq_pkg::ADDR_W-1:0]     paddr,
  input  logic [heq_pkg::DATA_W-1:0]     pwdata,
  output logic [heq_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,  // waiting for a transfer
    S_CNT  = 7'b0000010,  // bin write-back, next transfer allowed
    S_MAP  = 7'b0000100,  // table data ready, load output register
    S_BRD  = 7'b0001000,  // build: read first bin
    S_BACC = 7'b0010000,  // build: accumulate, start level unit
    S_BLVL = 7'b0100000,  // build: wait for level, write table
    S_BFIN = 7'b1000000   // build done: read table for the pending pixel
  } state_e;

  state_e                        state_q, state_d;
  logic [heq_pkg::LEVELS-1:0]    bvalid_q, bvalid_d;
  heq_pkg::count_t               total_q, total_d;
  logic                          ready_q, ready_d;
  heq_pkg::level_t               max_level_q, max_level_d;
  heq_pkg::idx_t                 cidx_q, cidx_d;
  logic                          fwd_q, fwd_d;
  heq_pkg::count_t               fwd_data_q, fwd_data_d;
  heq_pkg::idx_t                 bidx_q, bidx_d;
  heq_pkg::count_t               cum_q, cum_d;
  heq_pkg::idx_t                 pend_q, pend_d;
  logic                          out_valid_q, out_valid_d;
  heq_pkg::level_t               mapped_q, mapped_d;

  logic                          accept;
  logic                          cfg_wr;
  heq_pkg::op_e                  op;
  heq_pkg::idx_t                 in_idx;
  heq_pkg::count_t               cnt_base;
  heq_pkg::count_t               cnt_sum;
  heq_pkg::count_t               cum_sum;

  logic                          bin_we, bin_re;
  heq_pkg::idx_t                 bin_raddr;
  heq_pkg::count_t               bin_rdata;
  logic                          tbl_we, tbl_re;
  heq_pkg::idx_t                 tbl_raddr;
  heq_pkg::level_t               tbl_rdata;

  heq_pkg::lvl_req_t             lvl_req;
  heq_pkg::lvl_rsp_t             lvl_rsp;

  // new items are taken while idle or during a bin write-back
  assign in_stall_o = !((state_q == S_IDLE) || (state_q == S_CNT));
  assign accept     = in_valid_i && !in_stall_o;
  assign op         = heq_pkg::op_e'(op_i);
  assign in_idx     = heq_pkg::clamp_idx(pixel_i, max_level_q);

  // apb: always ready, single register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[heq_pkg::ADDR_W-1:2] == heq_pkg::REG_MAX_LEVEL);
  assign prdata = (paddr[heq_pkg::ADDR_W-1:2] == heq_pkg::REG_MAX_LEVEL) ?
                  heq_pkg::DATA_W'(max_level_q) : '0;

  // bin value for the write-back: forwarded if the previous count hit it
  assign cnt_base = fwd_q ? fwd_data_q : (bvalid_q[cidx_q] ? bin_rdata : '0);
  assign cnt_sum  = cnt_base + 1'b1;
  assign cum_sum  = cum_q + (bvalid_q[bidx_q] ? bin_rdata : '0);

  always_comb begin
    state_d     = state_q;
    bvalid_d    = bvalid_q;
    total_d     = total_q;
    ready_d     = ready_q;
    max_level_d = max_level_q;
    cidx_d      = cidx_q;
    fwd_d       = 1'b0;
    fwd_data_d  = fwd_data_q;
    bidx_d      = bidx_q;
    cum_d       = cum_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    mapped_d    = mapped_q;
    bin_we      = 1'b0;
    bin_re      = 1'b0;
    bin_raddr   = in_idx;
    tbl_we      = 1'b0;
    tbl_re      = 1'b0;
    tbl_raddr   = in_idx;
    lvl_req.start = 1'b0;
    lvl_req.cum   = cum_sum;
    lvl_req.level = max_level_q;
    lvl_req.total = total_q;

    unique case (state_q)
      S_IDLE: ;
      S_CNT: begin
        // write back the incremented bin
        bin_we           = 1'b1;
        bvalid_d[cidx_q] = 1'b1;
        state_d          = S_IDLE;
      end
      S_MAP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          mapped_d    = tbl_rdata;
          state_d     = S_IDLE;
        end
      end
      S_BRD: begin
        bin_re    = 1'b1;
        bin_raddr = bidx_q;
        state_d   = S_BACC;
      end
      S_BACC: begin
        cum_d         = cum_sum;
        lvl_req.start = 1'b1;
        state_d       = S_BLVL;
      end
      S_BLVL: begin
        if (lvl_rsp.done) begin
          tbl_we = 1'b1;
          if (bidx_q == heq_pkg::LAST_IDX) begin
            ready_d = 1'b1;
            state_d = S_BFIN;
          end else begin
            // prefetch the next bin while writing this level
            bidx_d    = bidx_q + 1'b1;
            bin_re    = 1'b1;
            bin_raddr = bidx_q + 1'b1;
            state_d   = S_BACC;
          end
        end
      end
      S_BFIN: begin
        tbl_re    = 1'b1;
        tbl_raddr = pend_q;
        state_d   = S_MAP;
      end
      default: state_d = S_IDLE;
    endcase

    if (accept) begin
      unique case (op)
        heq_pkg::OP_CLEAR: begin
          // wins over a write-back in the same cycle
          bvalid_d = '0;
          total_d  = '0;
          ready_d  = 1'b0;
        end
        heq_pkg::OP_COUNT: begin
          if (total_q != heq_pkg::TOTAL_MAX) begin
            bin_re     = 1'b1;
            cidx_d     = in_idx;
            total_d    = total_q + 1'b1;
            ready_d    = 1'b0;
            fwd_d      = (state_q == S_CNT) && (cidx_q == in_idx);
            fwd_data_d = cnt_sum;
            state_d    = S_CNT;
          end
        end
        heq_pkg::OP_MAP: begin
          pend_d = in_idx;
          if (ready_q) begin
            tbl_re  = 1'b1;
            state_d = S_MAP;
          end else begin
            bidx_d  = '0;
            cum_d   = '0;
            state_d = S_BRD;
          end
        end
        heq_pkg::OP_NONE: ;
      endcase
    end

    if (cfg_wr) begin
      max_level_d = pwdata[heq_pkg::LEVEL_W-1:0];
      ready_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bvalid_q    <= '0;
      total_q     <= '0;
      ready_q     <= 1'b0;
      max_level_q <= heq_pkg::MAX_LEVEL_RST;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bvalid_q    <= bvalid_d;
      total_q     <= total_d;
      ready_q     <= ready_d;
      max_level_q <= max_level_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cidx_q     <= cidx_d;
    fwd_data_q <= fwd_data_d;
    bidx_q     <= bidx_d;
    cum_q      <= cum_d;
    pend_q     <= pend_d;
    mapped_q   <= mapped_d;
  end

  assign out_valid_o = out_valid_q;
  assign mapped_o    = mapped_q;

  // histogram bins
  heq_ram #(
    .WIDTH (heq_pkg::COUNT_BITS),
    .DEPTH (heq_pkg::LEVELS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (cidx_q),
    .wdata_i (cnt_sum),
    .re_i    (bin_re),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  // equalized level table
  heq_ram #(
    .WIDTH (heq_pkg::LEVEL_W),
    .DEPTH (heq_pkg::LEVELS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (bidx_q),
    .wdata_i (lvl_rsp.quot),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  heq_lvl u_lvl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lvl_req),
    .rsp_o  (lvl_rsp)
  );

`ifndef ASSERT_OFF
  // forwarding only ever feeds a write-back
  a_fwd_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (state_q == S_CNT))
    else $error("forwarded bin outside write-back");

  // the level unit answers only while the build waits for it
  a_lvl_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_rsp.done |-> (state_q == S_BLVL))
    else $error("level result with no build waiting");

  // a write-back always follows a counted pixel
  a_cnt_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CNT) |-> (total_q != '0))
    else $error("bin write-back with empty total");

  // a result appears only out of the table read
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_MAP))
    else $error("result loaded outside map state");
`endif

endmodule
